// ===== hdl/tscd_pkg.sv =====
// Package for the tempo snapshot change detector.
// Holds field widths, constants, and the command and status types shared by the modules.
// No dependencies.
package tscd_pkg;

    localparam int BPM_W    = 26;
    localparam int ORIGIN_W = 63;
    localparam int BEAT_W   = 64;
    localparam int QIN_W    = 32;
    localparam int QOUT_W   = 16;
    localparam int PEERS_W  = 16;
    localparam int TEMPO_W  = 58;
    localparam int LAT_W    = 32;
    localparam int EPS_W    = 33;
    localparam int DIV_W    = 64;
    localparam int S_DATA_W = 208;
    localparam int M_DATA_W = 256;
    localparam int CFG_W    = 33;
    localparam int CFG_AW   = 1;

    localparam logic [CFG_AW-1:0] REG_BEAT_EPSILON  = 1'd0;
    localparam logic [CFG_AW-1:0] REG_LATENCY_VALUE = 1'd1;

    localparam logic [EPS_W-1:0]  EPS_RESET  = 33'd4294967;
    localparam logic [BPM_W-1:0]  BPM_MIN    = 26'd65536;
    localparam logic [BPM_W-1:0]  BPM_MAX    = 26'd65470464;
    localparam logic [DIV_W-1:0]  MPB_HI     = 64'd915;
    localparam logic [DIV_W-1:0]  MPB_LO     = 64'h8700_0000_0000_0000;
    localparam logic [14:0]       REL_TOL    = 15'd20000;
    localparam logic [DIV_W-1:0]  INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_phase;
        logic tempo_fin;
        logic cmp1;
        logic cmp2;
        logic ph1;
        logic ph2;
        logic ph3;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_phase;
        logic bypass;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/tscd_div.sv =====
// Restoring divider for the tempo snapshot change detector, one quotient bit per cycle.
// Divides a 128-bit numerator hi:lo by a 64-bit divisor, with hi below the divisor.
// Depends on tscd_pkg.
module tscd_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tscd_pkg::DIV_W-1:0]   num_hi,
    input  logic [tscd_pkg::DIV_W-1:0]   num_lo,
    input  logic [tscd_pkg::DIV_W-1:0]   den,
    output logic [tscd_pkg::DIV_W-1:0]   quo,
    output logic [tscd_pkg::DIV_W-1:0]   rem,
    output logic                         done
);

    logic [tscd_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [tscd_pkg::DIV_W-1:0] lo_reg, lo_next;
    logic [tscd_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [tscd_pkg::DIV_W-1:0] den_reg, den_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [tscd_pkg::DIV_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, lo_reg[tscd_pkg::DIV_W-1]};
        if (start) begin
            rem_next  = num_hi;
            lo_next   = num_lo;
            den_next  = den;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            lo_next = {lo_reg[tscd_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial[tscd_pkg::DIV_W-1:0] - den_reg;
                quo_next = {quo_reg[tscd_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[tscd_pkg::DIV_W-1:0];
                quo_next = {quo_reg[tscd_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ===== hdl/tscd_dp.sv =====
// Datapath of the tempo snapshot change detector: input capture, stored snapshot,
// tempo and phase checks, configuration registers and the output register.
// Depends on tscd_pkg and tscd_div.
module tscd_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tscd_pkg::cmd_t                  cmd,
    output tscd_pkg::status_t               status,
    input  logic [tscd_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tscd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [tscd_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [tscd_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [tscd_pkg::BPM_W-1:0]    bpm_in;
    logic [tscd_pkg::QOUT_W-1:0]   quant_in;
    logic [tscd_pkg::BPM_W-1:0]    bpm_reg;
    logic [tscd_pkg::ORIGIN_W-1:0] origin_reg;
    logic [tscd_pkg::BEAT_W-1:0]   beat_reg;
    logic [tscd_pkg::QOUT_W-1:0]   quant_reg;
    logic                          play_reg;
    logic [tscd_pkg::PEERS_W-1:0]  peers_reg;
    logic [tscd_pkg::TEMPO_W-1:0]  tempo_reg;
    logic                          dneg_reg;
    logic [tscd_pkg::DIV_W-1:0]    mag_reg;
    logic [tscd_pkg::TEMPO_W-1:0]  d_reg;
    logic                          fdiff_reg;
    logic                          bypass_reg;
    logic                          changed_reg;
    logic [tscd_pkg::DIV_W-1:0]    qmag_reg;
    logic [tscd_pkg::BEAT_W-1:0]   pred_reg;
    logic [tscd_pkg::TEMPO_W-1:0]  prev_tempo_reg;
    logic [tscd_pkg::ORIGIN_W-1:0] prev_origin_reg;
    logic [tscd_pkg::BEAT_W-1:0]   prev_beat_reg;
    logic [tscd_pkg::QOUT_W-1:0]   prev_quant_reg;
    logic                          prev_play_reg;
    logic [tscd_pkg::PEERS_W-1:0]  prev_peers_reg;
    logic                          prev_valid_reg;
    logic [tscd_pkg::EPS_W-1:0]    eps_reg;
    logic [tscd_pkg::LAT_W-1:0]    lat_reg;
    logic                          m_tvalid_reg;
    logic [tscd_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                          m_tuser_reg;

    logic [tscd_pkg::DIV_W-1:0]    div_hi, div_lo, div_den, div_q, div_r;
    logic                          div_done;
    logic [tscd_pkg::DIV_W-1:0]    dt;
    logic [tscd_pkg::DIV_W-1:0]    prev_tempo_ext;
    logic [tscd_pkg::DIV_W-1:0]    bpm_ext;
    logic                          t_inc, p_inc;
    logic [72:0]                   prod;
    logic [tscd_pkg::DIV_W:0]      qinc;
    logic [tscd_pkg::DIV_W:0]      psum;
    logic [tscd_pkg::DIV_W:0]      bsub;
    logic [tscd_pkg::DIV_W:0]      babs;
    logic [tscd_pkg::LAT_W-1:0]    lat_out;

    assign bpm_in = (s_tdata[25:0] <= tscd_pkg::BPM_MIN) ? tscd_pkg::BPM_MIN :
                    (s_tdata[25:0] > tscd_pkg::BPM_MAX) ? tscd_pkg::BPM_MAX : s_tdata[25:0];
    assign quant_in = (s_tdata[184:169] == '0) ? 16'd1 : s_tdata[184:169];

    assign prev_tempo_ext = {6'd0, prev_tempo_reg};
    assign bpm_ext        = {38'd0, bpm_reg};
    assign div_hi  = cmd.div_phase ? mag_reg : tscd_pkg::MPB_HI;
    assign div_lo  = cmd.div_phase ? '0 : tscd_pkg::MPB_LO;
    assign div_den = cmd.div_phase ? prev_tempo_ext : bpm_ext;

    tscd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_hi  (div_hi),
        .num_lo  (div_lo),
        .den     (div_den),
        .quo     (div_q),
        .rem     (div_r),
        .done    (div_done)
    );

    assign dt    = {1'b0, s_tdata[88:26]} - {1'b0, prev_origin_reg};
    assign t_inc = div_r >= (bpm_ext - div_r);
    assign p_inc = (div_r >= (prev_tempo_ext - div_r)) && (div_q != '1);
    assign prod  = {15'd0, d_reg} * {58'd0, tscd_pkg::REL_TOL};
    assign qinc  = {1'b0, div_q} + {64'd0, p_inc};
    assign psum  = dneg_reg ? ({prev_beat_reg[63], prev_beat_reg} - {1'b0, qmag_reg})
                            : ({prev_beat_reg[63], prev_beat_reg} + {1'b0, qmag_reg});
    assign bsub  = {pred_reg[63], pred_reg} - {beat_reg[63], beat_reg};
    assign babs  = bsub[64] ? (~bsub + 65'd1) : bsub;
    assign lat_out = prev_valid_reg ? lat_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
            eps_reg        <= tscd_pkg::EPS_RESET;
            lat_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    tscd_pkg::REG_BEAT_EPSILON:  eps_reg <= cfg_wdata;
                    tscd_pkg::REG_LATENCY_VALUE: lat_reg <= cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                m_tvalid_reg   <= 1'b1;
                prev_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            bpm_reg    <= bpm_in;
            origin_reg <= s_tdata[88:26];
            beat_reg   <= s_tdata[152:89];
            quant_reg  <= quant_in;
            play_reg   <= s_tdata[185];
            peers_reg  <= s_tdata[201:186];
            dneg_reg   <= dt[63];
            mag_reg    <= dt[63] ? (~dt + 64'd1) : dt;
        end
        if (cmd.tempo_fin) begin
            tempo_reg <= div_q[57:0] + {57'd0, t_inc};
        end
        if (cmd.cmp1) begin
            d_reg      <= (tempo_reg >= prev_tempo_reg) ? (tempo_reg - prev_tempo_reg)
                                                        : (prev_tempo_reg - tempo_reg);
            fdiff_reg  <= (play_reg != prev_play_reg) || (peers_reg != prev_peers_reg) ||
                          (quant_reg != prev_quant_reg);
            bypass_reg <= (prev_tempo_reg == '0) || (mag_reg >= prev_tempo_ext);
        end
        if (cmd.cmp2) begin
            changed_reg <= !prev_valid_reg || fdiff_reg || (prod > {15'd0, prev_tempo_reg});
        end
        if (cmd.ph1) begin
            qmag_reg <= (bypass_reg || qinc > {1'b0, tscd_pkg::INT64_MAX}) ?
                        tscd_pkg::INT64_MAX : qinc[63:0];
        end
        if (cmd.ph2) begin
            if (psum[64] != psum[63]) begin
                pred_reg <= psum[64] ? 64'h8000_0000_0000_0000 : tscd_pkg::INT64_MAX;
            end else begin
                pred_reg <= psum[63:0];
            end
        end
        if (cmd.ph3) begin
            changed_reg <= babs > {32'd0, eps_reg};
        end
        if (cmd.emit) begin
            m_tdata_reg     <= {6'd0, lat_out, peers_reg, play_reg, quant_reg, beat_reg,
                                origin_reg, tempo_reg};
            m_tuser_reg     <= changed_reg;
            prev_tempo_reg  <= tempo_reg;
            prev_origin_reg <= origin_reg;
            prev_beat_reg   <= beat_reg;
            prev_quant_reg  <= quant_reg;
            prev_play_reg   <= play_reg;
            prev_peers_reg  <= peers_reg;
        end
    end

    assign status.div_done   = div_done;
    assign status.need_phase = !changed_reg;
    assign status.bypass     = bypass_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/tscd_ctrl.sv =====
// Controller of the tempo snapshot change detector.
// Sequences capture, the two divisions, the checks and the output write.
// Depends on tscd_pkg.
module tscd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tscd_pkg::status_t   status,
    output tscd_pkg::cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TDIV   = 4'd1;
    localparam logic [3:0] ST_TWAIT  = 4'd2;
    localparam logic [3:0] ST_CMP1   = 4'd3;
    localparam logic [3:0] ST_CMP2   = 4'd4;
    localparam logic [3:0] ST_DECIDE = 4'd5;
    localparam logic [3:0] ST_PDIV   = 4'd6;
    localparam logic [3:0] ST_PWAIT  = 4'd7;
    localparam logic [3:0] ST_PH1    = 4'd8;
    localparam logic [3:0] ST_PH2    = 4'd9;
    localparam logic [3:0] ST_PH3    = 4'd10;
    localparam logic [3:0] ST_EMIT   = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_TWAIT;
            end
            ST_TWAIT: begin
                if (status.div_done) begin
                    cmd.tempo_fin = 1'b1;
                    state_next    = ST_CMP1;
                end
            end
            ST_CMP1: begin
                cmd.cmp1   = 1'b1;
                state_next = ST_CMP2;
            end
            ST_CMP2: begin
                cmd.cmp2   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                priority if (!status.need_phase) begin
                    state_next = ST_EMIT;
                end else if (status.bypass) begin
                    state_next = ST_PH1;
                end else begin
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_phase = 1'b1;
                state_next    = ST_PWAIT;
            end
            ST_PWAIT: begin
                cmd.div_phase = 1'b1;
                if (status.div_done) begin
                    state_next = ST_PH1;
                end
            end
            ST_PH1: begin
                cmd.ph1    = 1'b1;
                state_next = ST_PH2;
            end
            ST_PH2: begin
                cmd.ph2    = 1'b1;
                state_next = ST_PH3;
            end
            ST_PH3: begin
                cmd.ph3    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/tempo_snapshot_change_detect.sv =====
// Tempo snapshot change detector, top level.
// One item at a time: the next item is accepted only after the result of the last has been
// written to the output register, which may wait for that register to be free. The phase
// check is skipped when not needed and saturates without dividing in its bypass case; the
// shared 64-step divider serves both the tempo and the phase divisions.
// Reset (aresetn, synchronous) forgets the previous snapshot and restores the registers.
// Depends on tscd_pkg, tscd_ctrl, tscd_dp and tscd_div.
module tempo_snapshot_change_detect (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tempo (Q10.16 BPM), origin time, origin beat, quantum, playing flag, peer count,
    // zero fill
    input  logic [tscd_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tempo (Q32 microseconds per beat), origin time, origin beat, whole quantum beats,
    // playing flag, peer count, latency, zero fill
    output logic [tscd_pkg::M_DATA_W-1:0]   m_tdata,
    // changed
    output logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [tscd_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [tscd_pkg::CFG_W-1:0]      cfg_wdata
);

    tscd_pkg::cmd_t    cmd;
    tscd_pkg::status_t status;

    tscd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tscd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== tb/sv/tb_tempo_snapshot_change_detect.sv =====
// Testbench for the tempo snapshot change detector: random and directed timeline updates,
// a built-in predictor of the snapshot fields and the change flag, and a check of each whole result.
// Depends on tscd_pkg and tempo_snapshot_change_detect.
module tb_tempo_snapshot_change_detect;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] peer_count;
        logic        is_playing;
        logic [31:0] quantum;
        logic [63:0] origin_beat;
        logic [62:0] origin_time;
        logic [25:0] bpm_raw;
    } update_t;

    typedef struct packed {
        logic [31:0] latency_out;
        logic [15:0] peers_out;
        logic        playing_out;
        logic [15:0] quant_whole;
        logic [63:0] beat_q32;
        logic [62:0] origin_out;
        logic [57:0] tempo_q32;
    } snap_t;

    typedef struct {
        snap_t s;
        logic  changed;
    } snap_exp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [tscd_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [tscd_pkg::M_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [tscd_pkg::CFG_AW-1:0] cfg_addr = tscd_pkg::REG_BEAT_EPSILON;
    logic [tscd_pkg::CFG_W-1:0] cfg_wdata = '0;

    tempo_snapshot_change_detect uut (.*);

    always #4 aclk = ~aclk;

    // Predictor state
    logic [32:0] eps_reg;
    logic [31:0] lat_reg;
    logic        have_prev;
    snap_t       prev_snap;

    update_t   pending_q[$];
    snap_exp_t expected_snaps[$];
    int        mismatches = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    longint    cycles = 0;
    bit        driver_hold = 0;

    function automatic logic [63:0] div_round(logic [127:0] num, logic [63:0] d);
        logic [127:0] q, r;
        q = num / d;
        r = num % d;
        if (r >= d - r) q = q + 1;
        return q[63:0];
    endfunction

    function automatic logic phase_missed(update_t u);
        logic signed [64:0] dt;
        logic [63:0] mag, q;
        logic signed [65:0] pred;
        logic [65:0] diff;
        dt = $signed({2'b00, u.origin_time}) - $signed({2'b00, prev_snap.origin_out});
        mag = dt < 0 ? 64'(-dt) : 64'(dt);
        if (prev_snap.tempo_q32 == 0 || mag >= 64'(prev_snap.tempo_q32))
            q = tscd_pkg::INT64_MAX;
        else begin
            q = div_round({mag, 64'd0}, 64'(prev_snap.tempo_q32));
            if (q > tscd_pkg::INT64_MAX) q = tscd_pkg::INT64_MAX;
        end
        pred = $signed({{2{prev_snap.beat_q32[63]}}, prev_snap.beat_q32})
             + (dt < 0 ? -$signed({2'b00, q}) : $signed({2'b00, q}));
        if (pred > 66'sh0_7FFF_FFFF_FFFF_FFFF) pred = 66'sh0_7FFF_FFFF_FFFF_FFFF;
        if (pred < -66'sh0_8000_0000_0000_0000) pred = -66'sh0_8000_0000_0000_0000;
        pred = pred - $signed({{2{u.origin_beat[63]}}, u.origin_beat});
        diff = pred < 0 ? 66'(-pred) : 66'(pred);
        return diff > {33'd0, eps_reg};
    endfunction

    function automatic void predict_snapshot(update_t u);
        snap_exp_t e;
        logic [25:0] bpm;
        logic [63:0] t, dlt;
        bpm = u.bpm_raw <= tscd_pkg::BPM_MIN ? tscd_pkg::BPM_MIN :
              (u.bpm_raw > tscd_pkg::BPM_MAX ? tscd_pkg::BPM_MAX : u.bpm_raw);
        t = div_round({tscd_pkg::MPB_HI, tscd_pkg::MPB_LO}, 64'(bpm));
        e.s.tempo_q32 = t[57:0];
        e.s.origin_out = u.origin_time;
        e.s.beat_q32 = u.origin_beat;
        e.s.quant_whole = u.quantum[31:16] == 0 ? 16'd1 : u.quantum[31:16];
        e.s.playing_out = u.is_playing;
        e.s.peers_out = u.peer_count;
        e.s.latency_out = have_prev ? lat_reg : 32'd0;
        if (!have_prev) e.changed = 1'b1;
        else if (prev_snap.playing_out != e.s.playing_out || prev_snap.peers_out != e.s.peers_out
                 || prev_snap.quant_whole != e.s.quant_whole) e.changed = 1'b1;
        else begin
            dlt = e.s.tempo_q32 >= prev_snap.tempo_q32 ? 64'(e.s.tempo_q32 - prev_snap.tempo_q32)
                                                       : 64'(prev_snap.tempo_q32 - e.s.tempo_q32);
            if (dlt > 64'(prev_snap.tempo_q32) / 20000) e.changed = 1'b1;
            else e.changed = phase_missed(u);
        end
        have_prev = 1'b1;
        prev_snap = e.s;
        expected_snaps.push_back(e);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
        end else if (send_gap > 0) begin
            if (s_tvalid) predict_snapshot(update_t'(s_tdata[201:0]));
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else begin
            if (s_tvalid) predict_snapshot(update_t'(s_tdata[201:0]));
            if (pending_q.size() > 0 && !driver_hold) begin
                s_tdata <= tscd_pkg::S_DATA_W'(pending_q.pop_front());
                s_tvalid <= 1'b1;
                send_gap <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        snap_t got;
        snap_exp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = snap_t'(m_tdata[249:0]);
                if (expected_snaps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h", got);
                end else begin
                    e = expected_snaps.pop_front();
                    if (got !== e.s || m_tuser !== e.changed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h changed %b, got %h changed %b",
                                     e.s, e.changed, got, m_tuser);
                    end
                end
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    recv_gap <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic update_t rand_update(update_t base, bit follow);
        update_t u;
        logic [63:0] r64;
        u.bpm_raw = $urandom_range(0, 7) == 0 ? 26'($urandom) : 26'($urandom_range(65536, 200 << 16));
        u.origin_time = {31'($urandom), 32'($urandom)};
        u.origin_beat = {32'($urandom), 32'($urandom)};
        u.quantum = $urandom;
        u.is_playing = 1'($urandom);
        u.peer_count = 16'($urandom);
        if (follow) begin
            u = base;
            r64 = {32'($urandom), 32'($urandom)};
            u.origin_time = base.origin_time + 63'($urandom_range(0, 3000000))
                          - ($urandom_range(0, 3) == 0 ? 63'd4000000 : 63'd0);
            u.bpm_raw = base.bpm_raw + 26'($urandom_range(0, 3)) - 26'd1;
            u.origin_beat = base.origin_beat + (r64 >> $urandom_range(20, 63));
        end
        return u;
    endfunction

    task automatic write_reg(logic [tscd_pkg::CFG_AW-1:0] idx, logic [tscd_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == tscd_pkg::REG_BEAT_EPSILON) eps_reg = val;
        else lat_reg = val[31:0];
    endtask

    task automatic drain;
        while (pending_q.size() > 0 || s_tvalid || expected_snaps.size() > 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    update_t u, last;
    int phase, k;
    logic [32:0] eps_set[4] = '{33'd0, 33'h1_0000_0000, 33'd4294967, 33'd1000000};

    initial begin
        eps_reg = tscd_pkg::EPS_RESET;
        lat_reg = '0;
        have_prev = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: extremes of tempo, quantum, origin and beat, and repeated snapshots.
        last = '0;
        for (k = 0; k < 20; k++) begin
            u = rand_update(last, k % 2 == 1);
            case (k)
                0: u.bpm_raw = '0;
                2: u.bpm_raw = 26'd65536;
                4: u.bpm_raw = '1;
                6: u.bpm_raw = tscd_pkg::BPM_MAX + 1;
                8: u.quantum = 32'h0000_FFFF;
                10: u.quantum = '1;
                12: begin u.origin_time = '1; u.origin_beat = 64'h7FFF_FFFF_FFFF_FFFF; end
                13: u.origin_time = '0;
                14: u.origin_beat = 64'h8000_0000_0000_0000;
                15: begin u = last; u.origin_time = '1; end
                17: u = last;
                default: ;
            endcase
            pending_q.push_back(u);
            last = u;
        end
        drain();
        for (phase = 0; phase < 5; phase++) begin
            write_reg(tscd_pkg::REG_BEAT_EPSILON, phase < 4 ? eps_set[phase] : 33'($urandom));
            write_reg(tscd_pkg::REG_LATENCY_VALUE, phase == 1 ? 33'hFFFF_FFFF : 33'($urandom));
            for (k = 0; k < 106; k++) begin
                u = rand_update(last, $urandom_range(0, 9) < 7);
                if ($urandom_range(0, 19) == 0) u = last;
                pending_q.push_back(u);
                last = u;
                if (k == 50 && phase == 2) begin
                    while (pending_q.size() > 0) @(posedge aclk);
                    driver_hold = 1;
                    while (s_tvalid || expected_snaps.size() > 0) @(posedge aclk);
                    driver_hold = 0;
                end
            end
            drain();
        end
        if (mismatches == 0) begin
            $display("** tempo_snapshot_change_detect: PASSED **");
        end else begin
            $display("** tempo_snapshot_change_detect: FAILED **");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (cycles > 600000) begin
            $display("** tempo_snapshot_change_detect: FAILED **");
            $finish;
        end
    end
endmodule
